// File: rtl/core/mla_pkg.sv
`timescale 1ns / 1ps

package mla_pkg;

   typedef enum logic [1:0] {
      EV_ATTACH   = 2'd0,
      EV_DETACH   = 2'd1,
      EV_ANNOUNCE = 2'd2,
      EV_TICK     = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_WAIT     = 2'd1,
      PH_ACCEPTED = 2'd2,
      PH_REJECTED = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      WHY_OK       = 2'd0,
      WHY_MISMATCH = 2'd1,
      WHY_UNKNOWN  = 2'd2
   } reason_type;

   typedef enum logic [2:0] {
      REG_GENERAL_TYPE    = 3'd0,
      REG_COLD_TYPE       = 3'd1,
      REG_GENERAL_ID      = 3'd2,
      REG_COLD_ID         = 3'd3,
      REG_TIMEOUT         = 3'd4
   } reg_index_type;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [3:0]  MIN_ANNOUNCE_LEN   = 4'd5;
   localparam logic [7:0]  GENERAL_TYPE_RST   = 8'd1;
   localparam logic [7:0]  COLD_TYPE_RST      = 8'd2;
   localparam logic [15:0] TIMEOUT_RST        = 16'd1000;
   localparam logic [15:0] ELAPSED_MAX        = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  general_type_code;
      logic [7:0]  cold_chain_type_code;
      logic [31:0] general_expected_id;
      logic [31:0] cold_chain_expected_id;
      logic [15:0] timeout_ticks;
   } cfg_type;

endpackage

// File: rtl/core/mla_req_if.sv
`timescale 1ns / 1ps

interface mla_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [3:0]  frame_length;
   logic [7:0]  announced_type;
   logic [31:0] announced_id;

   modport source (
      output valid, req_type, frame_length, announced_type, announced_id,
      input  ready
   );
   modport sink (
      input  valid, req_type, frame_length, announced_type, announced_id,
      output ready
   );
endinterface

// File: rtl/core/mla_rsp_if.sv
`timescale 1ns / 1ps

interface mla_rsp_if;
   logic        valid;
   logic        ready;
   logic        reply_valid;
   logic [7:0]  reply_type;
   logic        reply_accepted;
   logic [1:0]  reply_reason;
   logic [1:0]  auth_status;
   logic [7:0]  linked_type;
   logic [31:0] linked_id;
   logic        link_ok;

   modport source (
      output valid, reply_valid, reply_type, reply_accepted, reply_reason,
             auth_status, linked_type, linked_id, link_ok,
      input  ready
   );
   modport sink (
      input  valid, reply_valid, reply_type, reply_accepted, reply_reason,
             auth_status, linked_type, linked_id, link_ok,
      output ready
   );
endinterface

// File: rtl/core/mla_csr.sv
`timescale 1ns / 1ps

module mla_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mla_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mla_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mla_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output mla_pkg::cfg_type                 cfg
);
   import mla_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_GENERAL_TYPE: cfg_in.general_type_code      = csr_pwdata[7:0];
            REG_COLD_TYPE:    cfg_in.cold_chain_type_code   = csr_pwdata[7:0];
            REG_GENERAL_ID:   cfg_in.general_expected_id    = csr_pwdata[31:0];
            REG_COLD_ID:      cfg_in.cold_chain_expected_id = csr_pwdata[31:0];
            REG_TIMEOUT:      cfg_in.timeout_ticks          = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_GENERAL_TYPE: csr_prdata = CSR_DATA_W'(cfg_ff.general_type_code);
         REG_COLD_TYPE:    csr_prdata = CSR_DATA_W'(cfg_ff.cold_chain_type_code);
         REG_GENERAL_ID:   csr_prdata = CSR_DATA_W'(cfg_ff.general_expected_id);
         REG_COLD_ID:      csr_prdata = CSR_DATA_W'(cfg_ff.cold_chain_expected_id);
         REG_TIMEOUT:      csr_prdata = CSR_DATA_W'(cfg_ff.timeout_ticks);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.general_type_code      <= GENERAL_TYPE_RST;
         cfg_ff.cold_chain_type_code   <= COLD_TYPE_RST;
         cfg_ff.general_expected_id    <= '0;
         cfg_ff.cold_chain_expected_id <= '0;
         cfg_ff.timeout_ticks          <= TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/mla_engine.sv
`timescale 1ns / 1ps

module mla_engine (
   input  logic             clock,
   input  logic             reset,
   input  mla_pkg::cfg_type cfg,
   mla_req_if.sink          req,
   mla_rsp_if.source        rsp
);
   import mla_pkg::*;

   // module record and wait counter
   phase_type   phase_ff, phase_in;
   logic [7:0]  stored_type_ff, stored_type_in;
   logic [31:0] stored_id_ff, stored_id_in;
   logic        accepted_ff, accepted_in;
   logic [15:0] elapsed_ff, elapsed_in;

   // result register
   logic        out_valid_ff;
   logic        reply_valid_ff, reply_valid_in;
   logic [7:0]  reply_type_ff, reply_type_in;
   logic        reply_acc_ff, reply_acc_in;
   reason_type  reply_why_ff, reply_why_in;

   logic        take;
   event_type   evt;
   logic        id_ok;
   logic [15:0] elapsed_inc;

   assign req.ready = !out_valid_ff || rsp.ready;
   assign take      = req.valid && req.ready;
   assign evt       = event_type'(req.req_type);
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;

   always_comb begin
      phase_in       = phase_ff;
      stored_type_in = stored_type_ff;
      stored_id_in   = stored_id_ff;
      accepted_in    = accepted_ff;
      elapsed_in     = elapsed_ff;
      reply_valid_in = 1'b0;
      reply_type_in  = '0;
      reply_acc_in   = 1'b0;
      reply_why_in   = WHY_OK;
      id_ok          = 1'b0;
      case (evt)
         EV_ATTACH: begin
            stored_type_in = '0;
            stored_id_in   = '0;
            accepted_in    = 1'b0;
            phase_in       = PH_WAIT;
            elapsed_in     = '0;
         end
         EV_DETACH: begin
            stored_type_in = '0;
            stored_id_in   = '0;
            accepted_in    = 1'b0;
            phase_in       = PH_IDLE;
            elapsed_in     = '0;
         end
         EV_ANNOUNCE: begin
            if (req.frame_length >= MIN_ANNOUNCE_LEN && phase_ff == PH_WAIT) begin
               // general pair wins when both type codes are equal
               if (req.announced_type == cfg.general_type_code) begin
                  id_ok        = (req.announced_id == cfg.general_expected_id);
                  reply_why_in = id_ok ? WHY_OK : WHY_MISMATCH;
               end else if (req.announced_type == cfg.cold_chain_type_code) begin
                  id_ok        = (req.announced_id == cfg.cold_chain_expected_id);
                  reply_why_in = id_ok ? WHY_OK : WHY_MISMATCH;
               end else begin
                  reply_why_in = WHY_UNKNOWN;
               end
               if (id_ok) begin
                  stored_type_in = req.announced_type;
                  stored_id_in   = req.announced_id;
                  accepted_in    = 1'b1;
                  phase_in       = PH_ACCEPTED;
               end else begin
                  stored_type_in = '0;
                  stored_id_in   = '0;
                  accepted_in    = 1'b0;
                  phase_in       = PH_REJECTED;
               end
               reply_valid_in = 1'b1;
               reply_type_in  = req.announced_type;
               reply_acc_in   = id_ok;
            end
         end
         EV_TICK: begin
            if (phase_ff == PH_WAIT) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= cfg.timeout_ticks) begin
                  stored_type_in = '0;
                  stored_id_in   = '0;
                  accepted_in    = 1'b0;
                  phase_in       = PH_REJECTED;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         stored_type_ff <= '0;
         stored_id_ff   <= '0;
         accepted_ff    <= 1'b0;
         elapsed_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (take) begin
            phase_ff       <= phase_in;
            stored_type_ff <= stored_type_in;
            stored_id_ff   <= stored_id_in;
            accepted_ff    <= accepted_in;
            elapsed_ff     <= elapsed_in;
            out_valid_ff   <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         reply_valid_ff <= reply_valid_in;
         reply_type_ff  <= reply_type_in;
         reply_acc_ff   <= reply_acc_in;
         reply_why_ff   <= reply_why_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.reply_valid    = reply_valid_ff;
   assign rsp.reply_type     = reply_type_ff;
   assign rsp.reply_accepted = reply_acc_ff;
   assign rsp.reply_reason   = reply_why_ff;
   assign rsp.auth_status    = phase_ff;
   assign rsp.linked_type    = stored_type_ff;
   assign rsp.linked_id      = stored_id_ff;
   assign rsp.link_ok        = accepted_ff;

`ifndef SYNTHESIS
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> out_valid_ff)
      else $error("request stalled with empty result register");

   a_link_ok_matches_phase: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (accepted_ff == (phase_ff == PH_ACCEPTED)))
      else $error("link_ok disagrees with phase");

   a_reply_sets_verdict: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && reply_valid_ff) |->
      ((reply_acc_ff && phase_ff == PH_ACCEPTED) ||
       (!reply_acc_ff && phase_ff == PH_REJECTED)))
      else $error("reply verdict disagrees with phase");

   a_announce_not_waiting: assert property (@(posedge clock) disable iff (reset)
      (take && evt == EV_ANNOUNCE && phase_ff != PH_WAIT) |=>
      (!reply_valid_ff && $stable(phase_ff)))
      else $error("announce outside waiting phase had an effect");

   a_detach_clears: assert property (@(posedge clock) disable iff (reset)
      (take && evt == EV_DETACH) |=>
      (phase_ff == PH_IDLE && elapsed_ff == 16'd0 && !accepted_ff))
      else $error("detach did not clear the record");
`endif

endmodule

// File: rtl/core/module_link_authenticator_top.sv
`timescale 1ns / 1ps
// a result is registered in the cycle after its request is accepted
// throughput: one request per cycle; the single result register stalls
// requests only while its result is held by the downstream side
// reset (synchronous): phase idle, record and wait counter cleared,
// configuration registers back to their default values

module module_link_authenticator_top (
   input  logic                             clock,
   input  logic                             reset,
   mla_req_if.sink                          req,
   mla_rsp_if.source                        rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mla_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mla_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mla_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import mla_pkg::*;

   cfg_type cfg;

   mla_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mla_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule
